>>> sv/fgoq_pkg.sv
// ----------------------------------------------------------------------------
// fgoq_pkg
// shared types and constants of the floor grouped order queue
// ----------------------------------------------------------------------------
package fgoq_pkg;

  localparam int FLOORS_DEF      = 4;
  localparam int ORDER_KINDS_DEF = 3;

  localparam int FLOOR_W       = 3;
  localparam int KIND_W        = 2;
  localparam int STATUS_W      = 3;
  localparam int LIGHT_FLOOR_W = 2;
  localparam int COUNT_OUT_W   = 4;

  typedef enum logic [0:0] {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED       = 3'd0,
    ST_DUPLICATE   = 3'd1,
    ST_REMOVED     = 3'd2,
    ST_EMPTY       = 3'd3,
    ST_OTHER_FLOOR = 3'd4
  } status_t;

  // one cell as seen by its neighbors
  typedef struct packed {
    logic [FLOOR_W-1:0] floor;
    logic [KIND_W-1:0]  kind;
    logic               valid;
    logic               hit;
    logic               seen;
  } cell_link_t;

  // broadcast controls to the cell row
  typedef struct packed {
    logic capture;
    logic insert;
    logic pop;
    logic any_hit;
  } cell_ctl_t;

endpackage

>>> sv/fgoq_req_if.sv
// ----------------------------------------------------------------------------
// fgoq_req_if
// request channel: valid/ready with an add or remove request
// ----------------------------------------------------------------------------
interface fgoq_req_if;
  import fgoq_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [FLOOR_W-1:0] order_floor;
  logic [KIND_W-1:0]  order_type;

  modport source (output valid, output op, output order_floor, output order_type,
                  input ready);
  modport sink   (input valid, input op, input order_floor, input order_type,
                  output ready);
endinterface

>>> sv/fgoq_rsp_if.sv
// ----------------------------------------------------------------------------
// fgoq_rsp_if
// result channel: valid/ready with status, light command and queue fill
// ----------------------------------------------------------------------------
interface fgoq_rsp_if;
  import fgoq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [LIGHT_FLOOR_W-1:0] light_floor;
  logic [KIND_W-1:0]        light_type;
  logic                     light_on;
  logic                     light_valid;
  logic                     last;
  logic [COUNT_OUT_W-1:0]   queue_count;

  modport source (output valid, output status, output light_floor, output light_type,
                  output light_on, output light_valid, output last,
                  output queue_count, input ready);
  modport sink   (input valid, input status, input light_floor, input light_type,
                  input light_on, input light_valid, input last,
                  input queue_count, output ready);
endinterface

>>> sv/fgoq_cell.sv
// ----------------------------------------------------------------------------
// fgoq_cell
// one queue slot: holds an entry, matches it, shifts with its neighbors
// ----------------------------------------------------------------------------
module fgoq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 4
) (
  input  logic                        clk,
  input  fgoq_pkg::cell_ctl_t         ctl,
  input  logic [CW-1:0]               count,
  input  logic [fgoq_pkg::FLOOR_W-1:0] req_floor,
  input  logic [fgoq_pkg::KIND_W-1:0]  req_kind,
  input  fgoq_pkg::cell_link_t        left,
  input  fgoq_pkg::cell_link_t        right,
  output fgoq_pkg::cell_link_t        link,
  output logic                        dup
);
  import fgoq_pkg::*;

  logic [FLOOR_W-1:0] floor;
  logic [KIND_W-1:0]  kind;
  logic               hit;
  logic               valid;
  logic               seen;
  logic               load_new;

  always_comb begin
    valid    = int'(count) > IDX;
    // some cell ahead of this one holds the requested floor
    seen     = left.seen | left.hit;
    // left neighbor is the first same-floor entry, or this is the tail slot
    load_new = (left.hit && !left.seen) || (!ctl.any_hit && left.valid && !valid);
    link.floor = floor;
    link.kind  = kind;
    link.valid = valid;
    link.hit   = hit;
    link.seen  = seen;
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      hit <= valid && (floor == req_floor);
      dup <= valid && (floor == req_floor) && (kind == req_kind);
    end
    if (ctl.insert) begin
      if (left.seen) begin
        floor <= left.floor;
        kind  <= left.kind;
      end else if (load_new) begin
        floor <= req_floor;
        kind  <= req_kind;
      end
    end else if (ctl.pop) begin
      floor <= right.floor;
      kind  <= right.kind;
    end
  end

endmodule

>>> sv/floor_grouped_order_queue_unit.sv
// ----------------------------------------------------------------------------
// floor_grouped_order_queue_unit
// elevator order queue kept in a row of shifting cells
// ----------------------------------------------------------------------------
// The queue holds up to FLOORS*ORDER_KINDS (floor, kind) orders, one per cell
// in a row; entry 0 is the front. An add request is accepted, then every cell
// compares its entry with the request, and then a commit step inserts the
// order right after the first entry of the same floor (or at the tail) by
// shifting the cells behind it one step, and gives one result. A duplicate,
// an out-of-range floor or kind, or a full queue gives a rejected result and
// leaves the queue alone. For a remove request, each entry taken off the
// front shifts the whole row one step toward the front and gives one result
// with its light-off command, up to ORDER_KINDS of them; an empty queue or a
// front entry of another floor gives a single result. Results go through an
// output register, so a result may wait for ready while the next request is
// accepted; a waiting result stalls the commit or shift step that would
// replace it. No clearing pass is needed after reset: the fill count alone
// marks live cells.
// ----------------------------------------------------------------------------
module floor_grouped_order_queue_unit #(
  parameter int FLOORS      = fgoq_pkg::FLOORS_DEF,
  parameter int ORDER_KINDS = fgoq_pkg::ORDER_KINDS_DEF
) (
  input logic          clk,
  input logic          rst,
  fgoq_req_if.sink     req,
  fgoq_rsp_if.source   rsp
);
  import fgoq_pkg::*;

  localparam int QDEPTH = FLOORS * ORDER_KINDS;
  localparam int CW     = $clog2(QDEPTH + 1);
  localparam int NW     = $clog2(ORDER_KINDS + 1);

  localparam cell_link_t FRONT_EDGE = '{floor: '0, kind: '0, valid: 1'b1,
                                        hit: 1'b0, seen: 1'b0};

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_ACT   = 3'b100
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [NW-1:0]      step;
  logic               req_op;
  logic [FLOOR_W-1:0] req_floor;
  logic [KIND_W-1:0]  req_kind;

  cell_ctl_t          ctl;
  cell_link_t         links       [QDEPTH];
  cell_link_t         left_links  [QDEPTH];
  cell_link_t         right_links [QDEPTH];
  logic [QDEPTH-1:0]  hit_vec;
  logic [QDEPTH-1:0]  dup_vec;

  // result being formed this cycle
  logic                     emit;
  logic                     finish;
  logic                     out_free;
  logic                     bad_add;
  logic                     more;
  status_t                  res_status;
  logic [FLOOR_W-1:0]       res_floor_m1;
  logic [KIND_W-1:0]        res_kind;
  logic                     res_on;
  logic                     res_light;
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  // --------------------------------------------------------------------------
  // cell row: each cell sees its front and back neighbor
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < QDEPTH; g++) begin : g_cell
    if (g == 0) begin : g_front
      assign left_links[g] = FRONT_EDGE;
    end else begin : g_mid
      assign left_links[g] = links[g-1];
    end
    if (g == QDEPTH - 1) begin : g_back
      assign right_links[g] = links[g];
    end else begin : g_inner
      assign right_links[g] = links[g+1];
    end

    fgoq_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .req_floor (req_floor),
      .req_kind  (req_kind),
      .left      (left_links[g]),
      .right     (right_links[g]),
      .link      (links[g]),
      .dup       (dup_vec[g])
    );

    assign hit_vec[g] = links[g].hit;
  end

  // --------------------------------------------------------------------------
  // decision for the commit / shift step
  // --------------------------------------------------------------------------
  always_comb begin
    out_free = !rsp.valid || rsp.ready;
    bad_add  = (int'(req_floor) < 1) || (int'(req_floor) > FLOORS) ||
               (int'(req_kind) >= ORDER_KINDS) || (int'(count) >= QDEPTH) ||
               (|dup_vec);
    // another entry of this floor follows the front one
    more     = (int'(count) > 1) && (links[1].floor == req_floor) &&
               (int'(step) + 1 < ORDER_KINDS);

    ctl          = '0;
    ctl.capture  = (state == S_CHECK);
    ctl.any_hit  = |hit_vec;
    emit         = 1'b0;
    finish       = 1'b0;
    count_next   = count;
    res_status   = ST_DUPLICATE;
    res_floor_m1 = '0;
    res_kind     = '0;
    res_on       = 1'b0;
    res_light    = 1'b0;

    if (state == S_ACT && out_free) begin
      emit = 1'b1;
      if (req_op == OP_ADD) begin
        finish = 1'b1;
        if (!bad_add) begin
          ctl.insert   = 1'b1;
          count_next   = count + 1'b1;
          res_status   = ST_ADDED;
          res_floor_m1 = req_floor - 1'b1;
          res_kind     = req_kind;
          res_on       = 1'b1;
          res_light    = 1'b1;
        end
      end else if (step == '0 && count == '0) begin
        finish     = 1'b1;
        res_status = ST_EMPTY;
      end else if (step == '0 && links[0].floor != req_floor) begin
        finish     = 1'b1;
        res_status = ST_OTHER_FLOOR;
      end else begin
        // take the front entry off, the row shifts forward
        ctl.pop      = 1'b1;
        count_next   = count - 1'b1;
        finish       = !more;
        res_status   = ST_REMOVED;
        res_floor_m1 = links[0].floor - 1'b1;
        res_kind     = links[0].kind;
        res_light    = 1'b1;
      end
    end

    count_ext = {{COUNT_OUT_W{1'b0}}, count_next};
  end

  assign req.ready = (state == S_IDLE);

  // --------------------------------------------------------------------------
  // sequencer and fill count
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      step  <= '0;
    end else begin
      count <= count_next;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= S_ACT;
          step  <= '0;
        end
        S_ACT: begin
          if (emit) begin
            step <= step + 1'b1;
          end
          if (finish) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_op    <= req.op;
      req_floor <= req.order_floor;
      req_kind  <= req.order_type;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.status      <= res_status;
      rsp.light_floor <= res_floor_m1[LIGHT_FLOOR_W-1:0];
      rsp.light_type  <= res_kind;
      rsp.light_on    <= res_on;
      rsp.light_valid <= res_light;
      rsp.last        <= finish;
      rsp.queue_count <= count_ext[COUNT_OUT_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= QDEPTH)
    else $error("queue fill count beyond depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && state != S_ACT) |=> count == $past(count))
    else $error("fill count changed outside the commit step");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> count != '0)
    else $error("pop from an empty cell row");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    ctl.insert |-> int'(count) < QDEPTH)
    else $error("insert into a full cell row");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (emit && rsp.valid) |-> rsp.ready)
    else $error("waiting result overwritten");

endmodule
